// File: sv/lkr_pkg.sv
package lkr_pkg;

  localparam int N_FRAMES   = 16;
  localparam int K_MAX      = 8;
  localparam int TIME_WIDTH = 32;

  localparam int FRAME_W = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
  localparam int EVT_W   = $clog2(N_FRAMES + 1);
  localparam int CNT_W   = $clog2(K_MAX + 1);
  localparam int HEAD_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int SUM_W   = $clog2(2 * K_MAX + 1);
  localparam int SCAN_W  = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
  localparam int KREG_W  = 4;
  localparam int FIU_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_SET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RECORD,
    OP_SET,
    OP_CLEAR
  } op_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    cmd_t               command;
    logic [FRAME_W-1:0] frame;
    logic               evictable_flag;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] victim_frame;
    logic               victim_found;
    logic [EVT_W-1:0]   evictable_count;
    logic               bad_frame;
  } out_item_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [FRAME_W-1:0]    frame;
    logic                  flag;
    logic [TIME_WIDTH-1:0] stamp;
    logic [CNT_W-1:0]      k;
  } cell_op_t;

  typedef struct packed {
    logic                  valid;
    logic                  inf_n;
    logic [TIME_WIDTH-1:0] stamp;
    logic [FRAME_W-1:0]    idx;
  } scan_t;

  typedef struct packed {
    logic tracked;
    logic evictable;
  } cell_stat_t;

  // ring index wrap, the sum stays below twice the ring size
  function automatic logic [HEAD_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (32'(s) >= K_MAX) r = s - SUM_W'(K_MAX);
    return HEAD_W'(r);
  endfunction

endpackage

// File: sv/lkr_cell.sv
module lkr_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lkr_pkg::FRAME_W-1:0] cell_idx,
  input  lkr_pkg::cell_op_t           op,
  input  lkr_pkg::scan_t              scan_in,
  output lkr_pkg::scan_t              scan_out,
  output lkr_pkg::cell_stat_t         stat
);

  logic                           tracked_r, tracked_nxt;
  logic                           evict_r, evict_nxt;
  logic [lkr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [lkr_pkg::HEAD_W-1:0]     head_r, head_nxt;
  logic [lkr_pkg::TIME_WIDTH-1:0] stamp_r [lkr_pkg::K_MAX];
  logic                           wr_en;
  logic [lkr_pkg::HEAD_W-1:0]     wr_slot;
  lkr_pkg::scan_t                 scan_r, scan_nxt, own;

  logic                       hit;
  logic [lkr_pkg::CNT_W-1:0]  cnt0;
  logic [lkr_pkg::HEAD_W-1:0] head0;
  logic [lkr_pkg::SUM_W-1:0]  c1;
  logic                       inf;
  logic [lkr_pkg::HEAD_W-1:0] rd_slot;

  assign hit = (op.frame == cell_idx);

  always_comb begin
    tracked_nxt = tracked_r;
    evict_nxt   = evict_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    wr_en       = 1'b0;
    cnt0        = tracked_r ? cnt_r : '0;
    head0       = tracked_r ? head_r : '0;
    wr_slot     = lkr_pkg::ring_wrap(lkr_pkg::SUM_W'(head0) + lkr_pkg::SUM_W'(cnt0));
    c1          = lkr_pkg::SUM_W'(cnt0) + lkr_pkg::SUM_W'(1);
    if (hit) begin
      case (op.kind)
        lkr_pkg::OP_RECORD: begin
          wr_en       = 1'b1;
          tracked_nxt = 1'b1;
          if (!tracked_r) evict_nxt = 1'b1;
          if (c1 > lkr_pkg::SUM_W'(op.k)) begin
            head_nxt = lkr_pkg::ring_wrap(lkr_pkg::SUM_W'(head0)
                                          + (c1 - lkr_pkg::SUM_W'(op.k)));
            cnt_nxt  = op.k;
          end else begin
            head_nxt = head0;
            cnt_nxt  = lkr_pkg::CNT_W'(c1);
          end
        end
        lkr_pkg::OP_SET: begin
          if (tracked_r) evict_nxt = op.flag;
        end
        lkr_pkg::OP_CLEAR: begin
          tracked_nxt = 1'b0;
          evict_nxt   = 1'b1;
          cnt_nxt     = '0;
          head_nxt    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= 1'b0;
      evict_r   <= 1'b1;
      cnt_r     <= '0;
      head_r    <= '0;
    end else begin
      tracked_r <= tracked_nxt;
      evict_r   <= evict_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) stamp_r[wr_slot] <= op.stamp;
  end

  // own candidate: oldest kept stamp if short of k accesses, else k-th most recent
  always_comb begin
    inf = (cnt_r < op.k);
    if (inf) rd_slot = head_r;
    else rd_slot = lkr_pkg::ring_wrap(lkr_pkg::SUM_W'(head_r)
                                      + lkr_pkg::SUM_W'(cnt_r - op.k));
    own.valid = tracked_r && evict_r;
    own.inf_n = !inf;
    own.stamp = stamp_r[rd_slot];
    own.idx   = cell_idx;
    // strict less keeps the lower index on a tie
    if (own.valid && (!scan_in.valid
        || {own.inf_n, own.stamp} < {scan_in.inf_n, scan_in.stamp})) begin
      scan_nxt = own;
    end else begin
      scan_nxt = scan_in;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  assign scan_out       = scan_r;
  assign stat.tracked   = tracked_r;
  assign stat.evictable = evict_r;

endmodule

// File: sv/lru_k_replacement_policy.sv
// channel  | direction | ports                         | handshake
// command  | in        | start, busy, in_data          | start && !busy
// result   | out       | out_valid, out_data           | one-cycle strobe, no stall
// config   | in        | cfg_valid, cfg_ready, cfg_*   | cfg_valid && cfg_ready
// record, set and remove are handled without leaving idle; the result shows in the next cycle
// and a new command may be started while it is shown.
// evict passes a best-candidate beat down the row of frame cells, one cell a
// cycle, while busy is held; the result shows in the cycle after the last busy cycle.
// synchronous active-low reset, no clearing pass; the receiver cannot stall.
module lru_k_replacement_policy (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  lkr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output lkr_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lkr_pkg::CFG_DATA_W-1:0] cfg_data
);

  lkr_pkg::state_t                state_r, state_nxt;
  logic [lkr_pkg::SCAN_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [lkr_pkg::KREG_W-1:0]     k_r;
  logic [lkr_pkg::FIU_W-1:0]      fiu_r;
  logic [lkr_pkg::TIME_WIDTH-1:0] time_r, time_nxt;
  logic [lkr_pkg::EVT_W-1:0]      evt_r, evt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  lkr_pkg::out_item_t             out_data_r, out_data_nxt;

  logic [lkr_pkg::CNT_W-1:0] k_eff;
  lkr_pkg::cell_op_t         op;
  lkr_pkg::scan_t            scan_chain [lkr_pkg::N_FRAMES];
  lkr_pkg::cell_stat_t       stat [lkr_pkg::N_FRAMES];
  lkr_pkg::scan_t            scan_none;
  lkr_pkg::scan_t            best;
  lkr_pkg::cell_stat_t       tgt;
  logic                      accept, bad;

  assign cfg_ready = 1'b1;
  assign scan_none = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= lkr_pkg::KREG_W'(2);
      fiu_r <= lkr_pkg::FIU_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lkr_pkg::REG_HISTORY_DEPTH: k_r   <= cfg_data[lkr_pkg::KREG_W-1:0];
        lkr_pkg::REG_FRAMES_IN_USE: fiu_r <= cfg_data[lkr_pkg::FIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (k_r == '0) k_eff = lkr_pkg::CNT_W'(1);
    else if (32'(k_r) > lkr_pkg::K_MAX) k_eff = lkr_pkg::CNT_W'(lkr_pkg::K_MAX);
    else k_eff = lkr_pkg::CNT_W'(k_r);
  end

  genvar gi;
  generate
    for (gi = 0; gi < lkr_pkg::N_FRAMES; gi++) begin : g_cell
      lkr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (lkr_pkg::FRAME_W'(gi)),
        .op       (op),
        .scan_in  ((gi == 0) ? scan_none : scan_chain[(gi == 0) ? 0 : gi - 1]),
        .scan_out (scan_chain[gi]),
        .stat     (stat[gi])
      );
    end
  endgenerate

  assign accept = start && !busy;
  assign busy   = (state_r != lkr_pkg::ST_IDLE);
  assign best   = scan_chain[lkr_pkg::N_FRAMES-1];
  assign tgt    = stat[in_data.frame];
  assign bad    = (32'(in_data.frame) >= 32'(fiu_r)) && (32'(fiu_r) <= lkr_pkg::N_FRAMES);

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    time_nxt      = time_r;
    evt_nxt       = evt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    op.kind       = lkr_pkg::OP_NONE;
    op.frame      = in_data.frame;
    op.flag       = in_data.evictable_flag;
    op.stamp      = (time_r != lkr_pkg::TIME_MAX) ? time_r + 1'b1 : time_r;
    op.k          = k_eff;
    case (state_r)
      lkr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == lkr_pkg::CMD_EVICT) begin
            state_nxt    = lkr_pkg::ST_SCAN;
            scan_cnt_nxt = '0;
          end else begin
            out_valid_nxt = 1'b1;
            if (!bad) begin
              case (in_data.command)
                lkr_pkg::CMD_RECORD: begin
                  op.kind  = lkr_pkg::OP_RECORD;
                  time_nxt = op.stamp;
                  if (!tgt.tracked) evt_nxt = evt_r + 1'b1;
                end
                lkr_pkg::CMD_SET: begin
                  op.kind = lkr_pkg::OP_SET;
                  if (tgt.tracked && in_data.evictable_flag && !tgt.evictable)
                    evt_nxt = evt_r + 1'b1;
                  else if (tgt.tracked && !in_data.evictable_flag && tgt.evictable)
                    evt_nxt = evt_r - 1'b1;
                end
                lkr_pkg::CMD_REMOVE: begin
                  if (tgt.tracked && tgt.evictable) begin
                    op.kind = lkr_pkg::OP_CLEAR;
                    evt_nxt = evt_r - 1'b1;
                  end
                end
                default: ;
              endcase
            end
            out_data_nxt.victim_frame    = '0;
            out_data_nxt.victim_found    = 1'b0;
            out_data_nxt.evictable_count = evt_nxt;
            out_data_nxt.bad_frame       = bad;
          end
        end
      end
      lkr_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        // last cell holds the winner once the beat has crossed every cell
        if (32'(scan_cnt_r) == lkr_pkg::N_FRAMES - 1) begin
          state_nxt     = lkr_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          op.frame      = best.idx;
          if (best.valid) begin
            op.kind = lkr_pkg::OP_CLEAR;
            evt_nxt = evt_r - 1'b1;
          end
          out_data_nxt.victim_frame    = best.valid ? best.idx : '0;
          out_data_nxt.victim_found    = best.valid;
          out_data_nxt.evictable_count = evt_nxt;
          out_data_nxt.bad_frame       = 1'b0;
        end
      end
      default: state_nxt = lkr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkr_pkg::ST_IDLE;
      scan_cnt_r  <= '0;
      time_r      <= '0;
      evt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      time_r      <= time_nxt;
      evt_r       <= evt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/lkr_checker.sv
module lkr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  lkr_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  lkr_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lkr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lkr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             failures
);
  import lkr_pkg::*;

  localparam int NF = N_FRAMES;
  localparam int KM = K_MAX;

  logic                  tracked  [NF];
  logic                  evictable[NF];
  int                    hits     [NF];
  int                    ring_head[NF];
  logic [TIME_WIDTH-1:0] stamps   [NF][KM];
  logic [TIME_WIDTH-1:0] clock_now;
  int                    evict_total;
  logic [KREG_W-1:0]     depth_reg;
  logic [FIU_W-1:0]      fiu_reg;
  out_item_t             expected_results[$];
  int                    mismatches;

  function automatic int k_used();
    if (depth_reg == 0) return 1;
    if (depth_reg > KM) return KM;
    return depth_reg;
  endfunction

  function automatic int frames_used();
    if (fiu_reg > NF) return NF;
    return fiu_reg;
  endfunction

  function automatic void untrack(input int f);
    tracked[f] = 1'b0;
    evictable[f] = 1'b1;
    hits[f] = 0;
    ring_head[f] = 0;
  endfunction

  function automatic void note_access(input int f);
    int kk;
    int c;
    kk = k_used();
    if (clock_now != TIME_MAX) clock_now = clock_now + 1;
    if (!tracked[f]) begin
      untrack(f);
      tracked[f] = 1'b1;
      evict_total++;
    end
    c = hits[f];
    stamps[f][(ring_head[f] + c) % KM] = clock_now;
    c++;
    if (c > kk) begin
      ring_head[f] = (ring_head[f] + c - kk) % KM;
      c = kk;
    end
    hits[f] = c;
  endfunction

  function automatic out_item_t predict(input in_item_t it);
    out_item_t r;
    int f;
    int kk;
    int best;
    logic have, inf, best_inf, better;
    logic [TIME_WIDTH-1:0] st, gap, best_gap, best_st;
    r = '0;
    f = it.frame;
    if (it.command != CMD_EVICT && f >= frames_used()) begin
      r.bad_frame = 1'b1;
    end else begin
      case (it.command)
        CMD_RECORD: note_access(f);
        CMD_SET: begin
          if (tracked[f]) begin
            if (it.evictable_flag && !evictable[f]) begin
              evictable[f] = 1'b1;
              evict_total++;
            end else if (!it.evictable_flag && evictable[f]) begin
              evictable[f] = 1'b0;
              evict_total--;
            end
          end
        end
        CMD_REMOVE: begin
          if (tracked[f] && evictable[f]) begin
            untrack(f);
            evict_total--;
          end
        end
        default: begin
          kk = k_used();
          have = 0; best_inf = 0; best_gap = '0; best_st = '0; best = 0;
          for (int i = 0; i < NF; i++) begin
            if (tracked[i] && evictable[i]) begin
              inf = hits[i] < kk;
              gap = '0;
              // infinite frames compare their oldest kept stamp
              if (inf) st = stamps[i][ring_head[i] % KM];
              else begin
                st = stamps[i][(ring_head[i] + hits[i] - kk) % KM];
                gap = clock_now - st;
              end
              if (!have) better = 1;
              else if (inf != best_inf) better = inf;
              else if (!inf && gap != best_gap) better = gap > best_gap;
              else better = st < best_st;
              if (better) begin
                have = 1; best_inf = inf; best_gap = gap; best_st = st; best = i;
              end
            end
          end
          if (have) begin
            untrack(best);
            evict_total--;
            r.victim_frame = FRAME_W'(best);
            r.victim_found = 1'b1;
          end
        end
      endcase
    end
    r.evictable_count = EVT_W'(evict_total);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        untrack(i);
        for (int j = 0; j < KM; j++) stamps[i][j] = '0;
      end
      clock_now = '0;
      evict_total = 0;
      depth_reg = KREG_W'(2);
      fiu_reg = FIU_W'(16);
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HISTORY_DEPTH) depth_reg = cfg_data[KREG_W-1:0];
        else if (cfg_index == REG_FRAMES_IN_USE) fiu_reg = cfg_data[FIU_W-1:0];
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.victim_frame !== out_data.victim_frame)
            $display("%0t: victim_frame expected %0d actual %0d", $time,
                     want.victim_frame, out_data.victim_frame);
          if (want.victim_found !== out_data.victim_found)
            $display("%0t: victim_found expected %0d actual %0d", $time,
                     want.victim_found, out_data.victim_found);
          if (want.evictable_count !== out_data.evictable_count)
            $display("%0t: evictable_count expected %0d actual %0d", $time,
                     want.evictable_count, out_data.evictable_count);
          if (want.bad_frame !== out_data.bad_frame)
            $display("%0t: bad_frame expected %0d actual %0d", $time,
                     want.bad_frame, out_data.bad_frame);
          if (want !== out_data) mismatches++;
        end
      end
      // a result never shows in the cycle its command is taken, so push after the pop
      if (start && !busy) expected_results.push_back(predict(in_data));
    end
    failures = mismatches + expected_results.size();
  end

endmodule

// File: sim/tb_lru_k_replacement_policy.sv
module tb_lru_k_replacement_policy;
  import lkr_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_HISTORY_DEPTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    failures;

  int cmds_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int fiu_now = 16;

  always #1 clk = ~clk;

  lru_k_replacement_policy DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lkr_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures)
  );

  always @(posedge clk) begin
    logic moved;
    moved = 0;
    if (rst_n) begin
      if (start && !busy) begin cmds_sent++; moved = 1; end
      if (out_valid) begin results_seen++; moved = 1; end
      if (cfg_valid && cfg_ready) moved = 1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("tb_lru_k_replacement_policy: done, errors");
      $finish;
    end
  end

  task automatic send(input cmd_t c, input int f, input logic flag);
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_data.command <= c;
    in_data.frame <= FRAME_W'(f);
    in_data.evictable_flag <= flag;
    start <= 1'b1;
    took = 0;
    while (!took) begin
      @(posedge clk);
      took = start && !busy;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (results_seen != cmds_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic took;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    took = 0;
    while (!took) begin
      @(posedge clk);
      took = cfg_ready;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    int f;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (r < 45) c = CMD_RECORD;
    else if (r < 65) c = CMD_SET;
    else if (r < 77) c = CMD_REMOVE;
    else c = CMD_EVICT;
    // mostly valid indices, some beyond the bound
    if (fiu_now > 0 && $urandom_range(0, 99) < 88)
      f = $urandom_range(0, (fiu_now > 16 ? 16 : fiu_now) - 1);
    else f = $urandom_range(0, 15);
    send(c, f, $urandom_range(0, 3) != 0);
  endtask

  initial begin
    int k_set[9];
    int fiu_set[9];
    k_set = '{2, 1, 8, 0, 15, 3, 4, 5, 8};
    fiu_set = '{16, 16, 16, 5, 31, 1, 0, 10, 2};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty evict, infinite ties, flags, remove, finite distances
    send(CMD_EVICT, 0, 1'b0);
    send(CMD_RECORD, 0, 1'b0);
    send(CMD_RECORD, 15, 1'b0);
    send(CMD_RECORD, 7, 1'b0);
    send(CMD_EVICT, 9, 1'b1);
    send(CMD_SET, 15, 1'b0);
    send(CMD_SET, 15, 1'b0);
    send(CMD_SET, 3, 1'b0);
    send(CMD_REMOVE, 15, 1'b0);
    send(CMD_SET, 15, 1'b1);
    send(CMD_REMOVE, 15, 1'b1);
    send(CMD_REMOVE, 4, 1'b0);
    send(CMD_RECORD, 7, 1'b0);
    send(CMD_RECORD, 1, 1'b0);
    send(CMD_RECORD, 1, 1'b0);
    send(CMD_RECORD, 7, 1'b0);
    send(CMD_RECORD, 1, 1'b0);
    send(CMD_EVICT, 0, 1'b0);
    send(CMD_EVICT, 0, 1'b0);
    send(CMD_EVICT, 0, 1'b0);
    settle();

    for (int p = 0; p < 9; p++) begin
      write_reg(REG_HISTORY_DEPTH, k_set[p]);
      write_reg(REG_FRAMES_IN_USE, fiu_set[p]);
      fiu_now = fiu_set[p];
      for (int n = 0; n < 170; n++) random_item();
      settle();
    end

    repeat (30) @(posedge clk);
    if (failures == 0) $display("tb_lru_k_replacement_policy: done, clean");
    else $display("tb_lru_k_replacement_policy: done, errors");
    $finish;
  end

endmodule
